>>> rtl/fdsum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsum_pkg
// Shared types and constants of the sync/length frame parser with sum16.
// ----------------------------------------------------------------------------
package fdsum_pkg;

   localparam int HEADER_BYTES = 9;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CHECK   = 2'd3
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_GOOD      = 2'd1;
   localparam logic [1:0] KIND_SUM_BAD   = 2'd2;
   localparam logic [1:0] KIND_TOO_LARGE = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ID       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPDATE_GID   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LARGE_LIMIT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_LIMIT = 3'd5;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [7:0]  own_device_id;
      logic [7:0]  update_group_id;
      logic [15:0] large_payload_limit;
      logic [15:0] normal_payload_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [15:0] payload_offset;
      logic [7:0]  source_id;
      logic [7:0]  dest_id;
      logic [7:0]  msg_type;
      logic [7:0]  group_id;
      logic [7:0]  command_id;
      logic [15:0] frame_length;
      logic        for_this_device;
   } result_type;

endpackage

>>> rtl/frame_deframer_with_sum16_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_deframer_with_sum16_core
// Byte-wise frame parser with 16-bit additive checksum and length guard.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle. Each byte is handled in the cycle it
// is accepted; a byte that yields a result (payload byte or frame verdict)
// lands in the result register in the next cycle. req_stall rises only when
// the incoming byte yields a result and the result register is still held by
// rsp_stall; bytes that yield nothing are always taken. Configuration writes
// take effect on the next cycle and csr_ready is always high.
module frame_deframer_with_sum16_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [7:0]                        rsp_payload_byte,
   output logic [15:0]                       rsp_payload_offset,
   output logic [7:0]                        rsp_source_id,
   output logic [7:0]                        rsp_dest_id,
   output logic [7:0]                        rsp_msg_type,
   output logic [7:0]                        rsp_group_id,
   output logic [7:0]                        rsp_command_id,
   output logic [15:0]                       rsp_frame_length,
   output logic                              rsp_for_this_device,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fdsum_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fdsum_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fdsum_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_data;
   logic       emit;
   logic       busy;
   logic       fire;

   assign req_stall = busy && emit;
   assign fire      = req_valid && !req_stall;

   fdsum_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fdsum_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .fire    (fire),
      .rx_byte (req_rx_byte),
      .emit    (emit),
      .result  (result)
   );

   fdsum_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && emit),
      .load_data (result),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind            = rsp_data.kind;
   assign rsp_payload_byte    = rsp_data.payload_byte;
   assign rsp_payload_offset  = rsp_data.payload_offset;
   assign rsp_source_id       = rsp_data.source_id;
   assign rsp_dest_id         = rsp_data.dest_id;
   assign rsp_msg_type        = rsp_data.msg_type;
   assign rsp_group_id        = rsp_data.group_id;
   assign rsp_command_id      = rsp_data.command_id;
   assign rsp_frame_length    = rsp_data.frame_length;
   assign rsp_for_this_device = rsp_data.for_this_device;

endmodule

>>> rtl/fdsum_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsum_csr
// Configuration registers, written by index over the csr channel.
// ----------------------------------------------------------------------------
module fdsum_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fdsum_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fdsum_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output fdsum_pkg::cfg_type               cfg
);
   import fdsum_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_FIRST:   cfg_in.sync_first           = csr_wdata[7:0];
            CSR_SYNC_SECOND:  cfg_in.sync_second          = csr_wdata[7:0];
            CSR_OWN_ID:       cfg_in.own_device_id        = csr_wdata[7:0];
            CSR_UPDATE_GID:   cfg_in.update_group_id      = csr_wdata[7:0];
            CSR_LARGE_LIMIT:  cfg_in.large_payload_limit  = csr_wdata;
            CSR_NORMAL_LIMIT: cfg_in.normal_payload_limit = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first           <= 8'd170;
         cfg_ff.sync_second          <= 8'd85;
         cfg_ff.own_device_id        <= 8'd1;
         cfg_ff.update_group_id      <= 8'd0;
         cfg_ff.large_payload_limit  <= 16'd1040;
         cfg_ff.normal_payload_limit <= 16'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/fdsum_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsum_parser
// Frame state machine: header capture, running sum, length check, verdict.
// ----------------------------------------------------------------------------
module fdsum_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  fdsum_pkg::cfg_type    cfg,
   input  logic                  fire,
   input  logic [7:0]            rx_byte,
   output logic                  emit,
   output fdsum_pkg::result_type result
);
   import fdsum_pkg::*;

   localparam logic [15:0] LAST_HDR_POS = 16'(HEADER_BYTES - 1);

   phase_type   phase_ff,  phase_in;
   logic [15:0] pos_ff,    pos_in;
   logic [15:0] sum_ff,    sum_in;
   logic [7:0]  src_ff,    src_in;
   logic [7:0]  dest_ff,   dest_in;
   logic [7:0]  type_ff,   type_in;
   logic [7:0]  gid_ff,    gid_in;
   logic [7:0]  cid_ff,    cid_in;
   logic [15:0] len_ff,    len_in;
   logic [7:0]  sum_lo_ff, sum_lo_in;
   logic [15:0] limit;
   logic [15:0] pos_inc;
   logic [15:0] byte_sum;

   assign pos_inc  = pos_ff + 16'd1;
   assign byte_sum = sum_ff + {8'd0, rx_byte};
   assign limit    = (gid_in == cfg.update_group_id) ? cfg.large_payload_limit
                                                     : cfg.normal_payload_limit;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      src_in    = src_ff;
      dest_in   = dest_ff;
      type_in   = type_ff;
      gid_in    = gid_ff;
      cid_in    = cid_ff;
      len_in    = len_ff;
      sum_lo_in = sum_lo_ff;
      emit      = 1'b0;
      result.kind           = KIND_PAYLOAD;
      result.payload_byte   = 8'd0;
      result.payload_offset = 16'd0;

      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == cfg.sync_first) begin
               phase_in = PH_HEADER;
               sum_in   = {8'd0, rx_byte};
               pos_in   = 16'd1;
            end
         end
         PH_HEADER: begin
            sum_in = byte_sum;
            case (pos_ff)
               16'd2:   src_in  = rx_byte;
               16'd3:   dest_in = rx_byte;
               16'd4:   type_in = rx_byte;
               16'd5:   gid_in  = rx_byte;
               16'd6:   cid_in  = rx_byte;
               16'd7:   len_in  = {len_ff[15:8], rx_byte};
               16'd8:   len_in  = {rx_byte, len_ff[7:0]};
               default: ;
            endcase
            if (pos_ff != LAST_HDR_POS) begin
               pos_in = pos_inc;
            end else if (len_in > limit) begin
               emit        = 1'b1;
               result.kind = KIND_TOO_LARGE;
               phase_in    = PH_IDLE;
               pos_in      = 16'd0;
               sum_in      = 16'd0;
               sum_lo_in   = 8'd0;
            end else begin
               pos_in   = 16'd0;
               phase_in = (len_in == 16'd0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_in                = byte_sum;
            emit                  = 1'b1;
            result.kind           = KIND_PAYLOAD;
            result.payload_byte   = rx_byte;
            result.payload_offset = pos_ff;
            if (pos_inc >= len_ff) begin
               phase_in = PH_CHECK;
               pos_in   = 16'd0;
            end else begin
               pos_in = pos_inc;
            end
         end
         PH_CHECK: begin
            if (pos_ff == 16'd0) begin
               sum_lo_in = rx_byte;
               pos_in    = 16'd1;
            end else begin
               emit        = 1'b1;
               result.kind = ({rx_byte, sum_lo_ff} == sum_ff) ? KIND_GOOD : KIND_SUM_BAD;
               phase_in    = PH_IDLE;
               pos_in      = 16'd0;
               sum_in      = 16'd0;
               sum_lo_in   = 8'd0;
            end
         end
         default: ;
      endcase

      result.source_id       = src_in;
      result.dest_id         = dest_in;
      result.msg_type        = type_in;
      result.group_id        = gid_in;
      result.command_id      = cid_in;
      result.frame_length    = len_in;
      result.for_this_device = (dest_in == cfg.own_device_id);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= 16'd0;
         sum_ff    <= 16'd0;
         src_ff    <= 8'd0;
         dest_ff   <= 8'd0;
         type_ff   <= 8'd0;
         gid_ff    <= 8'd0;
         cid_ff    <= 8'd0;
         len_ff    <= 16'd0;
         sum_lo_ff <= 8'd0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         src_ff    <= src_in;
         dest_ff   <= dest_in;
         type_ff   <= type_in;
         gid_ff    <= gid_in;
         cid_ff    <= cid_in;
         len_ff    <= len_in;
         sum_lo_ff <= sum_lo_in;
      end
   end

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (pos_ff == 16'd0 && sum_ff == 16'd0))
      else $error("idle with stale position or sum");

   a_hdr_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (pos_ff != 16'd0 && pos_ff <= LAST_HDR_POS))
      else $error("header position out of range");

   a_pay_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (pos_ff < len_ff))
      else $error("payload position past length");

   a_chk_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CHECK) |-> (pos_ff <= 16'd1))
      else $error("checksum position out of range");

endmodule

>>> rtl/fdsum_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsum_out_reg
// Result register between the parser and the rsp channel.
// ----------------------------------------------------------------------------
module fdsum_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  fdsum_pkg::result_type load_data,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fdsum_pkg::result_type rsp_data
);
   import fdsum_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign busy      = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !busy)
      else $error("result register overwritten while held");

   a_load_shown: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded transaction not presented");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_stall && !load) |=> !valid_ff)
      else $error("taken transaction presented twice");

endmodule

>>> dv/frame_deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_deframer_checker
// Watches the byte, result and register channels of the frame parser, keeps
// its own parse state and register copy, and compares every result
// transaction field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module frame_deframer_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_kind,
   input  logic [7:0]                        rsp_payload_byte,
   input  logic [15:0]                       rsp_payload_offset,
   input  logic [7:0]                        rsp_source_id,
   input  logic [7:0]                        rsp_dest_id,
   input  logic [7:0]                        rsp_msg_type,
   input  logic [7:0]                        rsp_group_id,
   input  logic [7:0]                        rsp_command_id,
   input  logic [15:0]                       rsp_frame_length,
   input  logic                              rsp_for_this_device,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [fdsum_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fdsum_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                errors,
   output int                                pending,
   output int                                results_checked,
   output int                                verdicts_checked,
   output bit                                frame_open
);
   import fdsum_pkg::*;

   localparam cfg_type CFG_AFTER_RESET = '{
      sync_first:           8'd170,
      sync_second:          8'd85,
      own_device_id:        8'd1,
      update_group_id:      8'd0,
      large_payload_limit:  16'd1040,
      normal_payload_limit: 16'd64
   };

   cfg_type     cfg;
   phase_type   rx_phase;
   logic [15:0] rx_pos;
   logic [15:0] rx_sum;
   logic [7:0]  sum_low;
   logic [7:0]  hdr_src;
   logic [7:0]  hdr_dest;
   logic [7:0]  hdr_type;
   logic [7:0]  hdr_gid;
   logic [7:0]  hdr_cid;
   logic [15:0] hdr_len;
   result_type  expected_results[$];

   function automatic result_type frame_result(input logic [1:0] kind,
                                               input logic [7:0] data,
                                               input logic [15:0] offset);
      result_type r;
      r.kind            = kind;
      r.payload_byte    = data;
      r.payload_offset  = offset;
      r.source_id       = hdr_src;
      r.dest_id         = hdr_dest;
      r.msg_type        = hdr_type;
      r.group_id        = hdr_gid;
      r.command_id      = hdr_cid;
      r.frame_length    = hdr_len;
      r.for_this_device = (hdr_dest == cfg.own_device_id);
      return r;
   endfunction

   task automatic return_to_idle();
      rx_phase = PH_IDLE;
      rx_pos   = '0;
      rx_sum   = '0;
      sum_low  = '0;
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_SYNC_FIRST:   cfg.sync_first           = value[7:0];
         CSR_SYNC_SECOND:  cfg.sync_second          = value[7:0];
         CSR_OWN_ID:       cfg.own_device_id        = value[7:0];
         CSR_UPDATE_GID:   cfg.update_group_id      = value[7:0];
         CSR_LARGE_LIMIT:  cfg.large_payload_limit  = value[15:0];
         CSR_NORMAL_LIMIT: cfg.normal_payload_limit = value[15:0];
         default: ;
      endcase
   endtask

   task automatic parse_rx_byte(input logic [7:0] b);
      logic [15:0] limit;
      case (rx_phase)
         PH_IDLE: begin
            if (b == cfg.sync_first) begin
               rx_phase = PH_HEADER;
               rx_sum   = {8'h00, b};
               rx_pos   = 16'd1;
            end
         end
         PH_HEADER: begin
            rx_sum = rx_sum + {8'h00, b};
            case (rx_pos)
               16'd2: hdr_src       = b;
               16'd3: hdr_dest      = b;
               16'd4: hdr_type      = b;
               16'd5: hdr_gid       = b;
               16'd6: hdr_cid       = b;
               16'd7: hdr_len[7:0]  = b;
               16'd8: hdr_len[15:8] = b;
               default: ;   // second sync byte is summed only
            endcase
            if (rx_pos + 1 < HEADER_BYTES) begin
               rx_pos = rx_pos + 16'd1;
            end else begin
               limit = (hdr_gid == cfg.update_group_id) ? cfg.large_payload_limit
                                                        : cfg.normal_payload_limit;
               if (hdr_len > limit) begin
                  expected_results.push_back(frame_result(KIND_TOO_LARGE, 8'h00, 16'h0000));
                  return_to_idle();
               end else begin
                  rx_pos   = '0;
                  rx_phase = (hdr_len == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            rx_sum = rx_sum + {8'h00, b};
            expected_results.push_back(frame_result(KIND_PAYLOAD, b, rx_pos));
            rx_pos = rx_pos + 16'd1;
            if (rx_pos >= hdr_len) begin
               rx_phase = PH_CHECK;
               rx_pos   = '0;
            end
         end
         default: begin
            if (rx_pos == 16'h0000) begin
               sum_low = b;
               rx_pos  = 16'd1;
            end else begin
               expected_results.push_back(frame_result(
                  ({b, sum_low} == rx_sum) ? KIND_GOOD : KIND_SUM_BAD, 8'h00, 16'h0000));
               return_to_idle();
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] seen);
      if (seen !== want) begin
         errors++;
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, seen);
      end
   endtask

   task automatic compare_result(input result_type want, input result_type seen);
      check_field("kind",            16'(want.kind),            16'(seen.kind));
      check_field("payload_byte",    16'(want.payload_byte),    16'(seen.payload_byte));
      check_field("payload_offset",  want.payload_offset,       seen.payload_offset);
      check_field("source_id",       16'(want.source_id),       16'(seen.source_id));
      check_field("dest_id",         16'(want.dest_id),         16'(seen.dest_id));
      check_field("msg_type",        16'(want.msg_type),        16'(seen.msg_type));
      check_field("group_id",        16'(want.group_id),        16'(seen.group_id));
      check_field("command_id",      16'(want.command_id),      16'(seen.command_id));
      check_field("frame_length",    want.frame_length,         seen.frame_length);
      check_field("for_this_device", 16'(want.for_this_device), 16'(seen.for_this_device));
   endtask

   always @(posedge clock) begin : monitor
      result_type seen;
      result_type want;
      if (reset) begin
         cfg      = CFG_AFTER_RESET;
         hdr_src  = '0;
         hdr_dest = '0;
         hdr_type = '0;
         hdr_gid  = '0;
         hdr_cid  = '0;
         hdr_len  = '0;
         return_to_idle();
         expected_results.delete();
         errors           = 0;
         results_checked  = 0;
         verdicts_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{kind: rsp_kind, payload_byte: rsp_payload_byte,
                     payload_offset: rsp_payload_offset, source_id: rsp_source_id,
                     dest_id: rsp_dest_id, msg_type: rsp_msg_type,
                     group_id: rsp_group_id, command_id: rsp_command_id,
                     frame_length: rsp_frame_length,
                     for_this_device: rsp_for_this_device};
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t result transaction: expected none, actual kind %0d",
                        $time, rsp_kind);
            end else begin
               want = expected_results.pop_front();
               compare_result(want, seen);
               results_checked++;
               if (want.kind != KIND_PAYLOAD) verdicts_checked++;
            end
         end
         if (req_valid && !req_stall) parse_rx_byte(req_rx_byte);
         if (csr_valid && csr_ready) write_register(csr_index, csr_wdata);
      end
      pending    = expected_results.size();
      frame_open = (rx_phase != PH_IDLE);
   end

endmodule

>>> dv/tb_frame_deframer_with_sum16_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_deframer_with_sum16_core
// Drives byte streams into the frame parser under several register settings:
// a short directed set of frames, then random frames with good and bad sums,
// limit-edge and oversize lengths, truncated frames and idle noise. Both
// channels idle and stall at random; the checker does all the comparison.
// ----------------------------------------------------------------------------
module tb_frame_deframer_with_sum16_core;
   import fdsum_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_rx_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_kind;
   logic [7:0]             rsp_payload_byte;
   logic [15:0]            rsp_payload_offset;
   logic [7:0]             rsp_source_id;
   logic [7:0]             rsp_dest_id;
   logic [7:0]             rsp_msg_type;
   logic [7:0]             rsp_group_id;
   logic [7:0]             rsp_command_id;
   logic [15:0]            rsp_frame_length;
   logic                   rsp_for_this_device;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int      errors;
   int      pending;
   int      results_checked;
   int      verdicts_checked;
   bit      frame_open;
   bit      quiet;
   int      frame_bytes;
   cfg_type cur_cfg;

   frame_deframer_with_sum16_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_offset  (rsp_payload_offset),
      .rsp_source_id       (rsp_source_id),
      .rsp_dest_id         (rsp_dest_id),
      .rsp_msg_type        (rsp_msg_type),
      .rsp_group_id        (rsp_group_id),
      .rsp_command_id      (rsp_command_id),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_for_this_device (rsp_for_this_device),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   frame_deframer_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_offset  (rsp_payload_offset),
      .rsp_source_id       (rsp_source_id),
      .rsp_dest_id         (rsp_dest_id),
      .rsp_msg_type        (rsp_msg_type),
      .rsp_group_id        (rsp_group_id),
      .rsp_command_id      (rsp_command_id),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_for_this_device (rsp_for_this_device),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .errors              (errors),
      .pending             (pending),
      .results_checked     (results_checked),
      .verdicts_checked    (verdicts_checked),
      .frame_open          (frame_open)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // result side: random stall after each accepted transaction, none while quiet
   initial begin
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            hold = quiet ? 0 : $urandom_range(0, 3);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++) send_byte(8'($urandom));
   endtask

   // fill < 0 gives random payload; cut >= 0 stops after that many bytes
   task automatic send_frame(input logic [7:0] dest, input logic [7:0] gid,
                             input logic [15:0] len, input int fill,
                             input bit bad_sum, input bit wrong_sync, input int cut);
      logic [7:0]  bytes_q[$];
      logic [15:0] sum;
      logic [15:0] limit;
      logic [7:0]  b;
      bytes_q.push_back(cur_cfg.sync_first);
      bytes_q.push_back(wrong_sync ? cur_cfg.sync_second ^ 8'($urandom_range(1, 255))
                                   : cur_cfg.sync_second);
      bytes_q.push_back(8'($urandom));
      bytes_q.push_back(dest);
      bytes_q.push_back(8'($urandom));
      bytes_q.push_back(gid);
      bytes_q.push_back(8'($urandom));
      bytes_q.push_back(len[7:0]);
      bytes_q.push_back(len[15:8]);
      limit = (gid == cur_cfg.update_group_id) ? cur_cfg.large_payload_limit
                                               : cur_cfg.normal_payload_limit;
      if (len <= limit) begin
         for (int i = 0; i < len; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            bytes_q.push_back(b);
         end
         sum = '0;
         foreach (bytes_q[i]) sum = sum + {8'h00, bytes_q[i]};
         if (bad_sum) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
         bytes_q.push_back(sum[7:0]);
         bytes_q.push_back(sum[15:8]);
      end
      foreach (bytes_q[i]) begin
         if (cut >= 0 && i >= cut) break;
         send_byte(bytes_q[i]);
         frame_bytes++;
      end
   endtask

   task automatic run_random(input int items, input bit noisy);
      int          target;
      int          lim;
      logic [7:0]  dest;
      logic [7:0]  gid;
      logic [15:0] len;
      target = frame_bytes + items;
      while (frame_bytes < target) begin
         if ($urandom_range(0, 15) == 0) quiet = !quiet;
         dest = $urandom_range(0, 1) ? cur_cfg.own_device_id : 8'($urandom);
         gid  = $urandom_range(0, 1) ? cur_cfg.update_group_id : 8'($urandom);
         lim  = int'((gid == cur_cfg.update_group_id) ? cur_cfg.large_payload_limit
                                                      : cur_cfg.normal_payload_limit);
         case ($urandom_range(0, 9))
            0, 1:    len = (lim <= 64) ? 16'(lim) : 16'($urandom_range(9, 64));
            2:       len = (lim < 65535) ? 16'(lim + 1) : 16'd3;
            3:       len = (lim < 65535) ? 16'($urandom_range(lim + 1, 65535)) : 16'd5;
            default: len = 16'($urandom_range(0, (lim < 8) ? lim : 8));
         endcase
         send_frame(dest, gid, len, -1, $urandom_range(0, 4) == 0,
                    $urandom_range(0, 7) == 0,
                    (noisy && $urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : -1);
         if (noisy && $urandom_range(0, 5) == 0) send_noise($urandom_range(1, 4));
      end
   endtask

   // close any open frame and wait until every result has come back
   task automatic drain();
      req_valid <= 1'b0;
      forever begin
         @(negedge clock);
         if (frame_open) begin
            @(posedge clock);
            send_byte(8'h00);
            req_valid <= 1'b0;
         end else if (pending == 0) begin
            break;
         end
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input cfg_type c);
      write_reg(CSR_SYNC_FIRST,   {8'($urandom), c.sync_first});
      write_reg(CSR_SYNC_SECOND,  {8'($urandom), c.sync_second});
      write_reg(CSR_OWN_ID,       {8'($urandom), c.own_device_id});
      write_reg(CSR_UPDATE_GID,   {8'($urandom), c.update_group_id});
      write_reg(CSR_LARGE_LIMIT,  c.large_payload_limit);
      write_reg(CSR_NORMAL_LIMIT, c.normal_payload_limit);
      write_reg(CSR_UNUSED,       16'($urandom));
      csr_valid <= 1'b0;
      cur_cfg = c;
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      c.sync_first           = 8'($urandom);
      c.sync_second          = 8'($urandom);
      c.own_device_id        = 8'($urandom);
      c.update_group_id      = 8'($urandom);
      c.large_payload_limit  = 16'($urandom_range(0, 1040));
      c.normal_payload_limit = 16'($urandom_range(0, 1040));
      return c;
   endfunction

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      quiet       = 1'b0;
      frame_bytes = 0;
      cur_cfg     = '{sync_first: 8'd170, sync_second: 8'd85, own_device_id: 8'd1,
                      update_group_id: 8'd0, large_payload_limit: 16'd1040,
                      normal_payload_limit: 16'd64};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: idle noise, zero length with bad second sync, oversize,
      // sync byte inside the payload with a bad sum
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(cur_cfg.own_device_id, cur_cfg.update_group_id, 16'd0, -1, 1'b0, 1'b1, -1);
      send_frame(8'h00, 8'hFF, 16'hFFFF, -1, 1'b0, 1'b0, -1);
      send_frame(8'hFF, cur_cfg.update_group_id, 16'd2, cur_cfg.sync_first, 1'b1, 1'b0, -1);
      run_random(200, 1'b1);
      drain();

      set_config('{sync_first: 8'h00, sync_second: 8'hFF, own_device_id: 8'hFF,
                   update_group_id: 8'hFF, large_payload_limit: 16'h0000,
                   normal_payload_limit: 16'h0000});
      run_random(150, 1'b1);
      drain();

      // all-ones payload at the limit makes the running sum wrap
      set_config('{sync_first: 8'hFF, sync_second: 8'h00, own_device_id: 8'h00,
                   update_group_id: 8'($urandom), large_payload_limit: 16'd300,
                   normal_payload_limit: 16'd16});
      send_frame(cur_cfg.own_device_id, cur_cfg.update_group_id, 16'd300, 8'hFF,
                 1'b0, 1'b0, -1);
      run_random(200, 1'b1);
      drain();

      set_config('{sync_first: 8'($urandom), sync_second: 8'($urandom),
                   own_device_id: 8'($urandom), update_group_id: 8'($urandom),
                   large_payload_limit: 16'd1, normal_payload_limit: 16'hFFFF});
      run_random(150, 1'b0);
      drain();

      repeat (2) begin
         set_config(random_config());
         run_random(150, 1'b1);
         drain();
      end

      @(negedge clock);
      $display("Checked %0d result transactions (%0d frame verdicts) from %0d frame bytes",
               results_checked, verdicts_checked, frame_bytes);
      $display("over six register settings, with idle noise and truncated frames.");
      if (errors == 0) begin
         $display("[frame_deframer_with_sum16_core] OK");
      end else begin
         $display("[frame_deframer_with_sum16_core] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[frame_deframer_with_sum16_core] ERROR");
      $finish;
   end

endmodule
